[rtl/core/vfm_pkg.sv]
package vfm_pkg;

   localparam int unsigned CHUNK_SIZE      = 16;
   localparam int unsigned VERTEX_CAPACITY = 65536;

   localparam int unsigned CoordW = 4;
   localparam int unsigned PosW   = 5;
   localparam int unsigned IdW    = 8;
   localparam int unsigned CntW   = 17;
   localparam int unsigned IdxW   = 16;

   localparam logic [CntW-1:0] CntMax    = {CntW{1'b1}};
   localparam logic [CntW-1:0] CntStep   = CntW'(4);
   localparam logic [CntW-1:0] CapLimit  = CntW'(VERTEX_CAPACITY);
   localparam logic [IdW-1:0]  LiquidRst = IdW'(9);
   localparam logic [IdW-1:0]  IdEmpty   = '0;

   // opcodes
   localparam logic OpTest  = 1'b0;
   localparam logic OpStart = 1'b1;

   // axis codes
   localparam logic [1:0] AxisX = 2'd0;
   localparam logic [1:0] AxisY = 2'd1;
   localparam logic [1:0] AxisZ = 2'd2;

   // record kinds and mesh selects
   localparam logic KindVertex = 1'b0;
   localparam logic KindIndex  = 1'b1;
   localparam logic MeshOpaque = 1'b0;
   localparam logic MeshClear  = 1'b1;

   // ten beats per face: four vertices then six indices
   localparam int unsigned StepW     = 4;
   localparam logic [StepW-1:0] NumVertex = StepW'(4);
   localparam logic [StepW-1:0] LastStep  = StepW'(9);

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QPtrW      = $clog2(QueueDepth);
   localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

   // quad corner offsets per axis, bit 0 = x, bit 1 = y, bit 2 = z
   localparam logic [2:0] QUAD_CORNER [3][4] = '{
      '{3'b000, 3'b100, 3'b110, 3'b010},
      '{3'b000, 3'b001, 3'b101, 3'b100},
      '{3'b001, 3'b000, 3'b010, 3'b011}
   };

   // corner texture coordinates per axis, bit 1 = u, bit 0 = v
   localparam logic [1:0] CORNER_UV [3][4] = '{
      '{2'b00, 2'b10, 2'b11, 2'b01},
      '{2'b00, 2'b10, 2'b11, 2'b01},
      '{2'b10, 2'b00, 2'b01, 2'b11}
   };

   localparam logic [1:0] TRI_ORDER [6] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3};

   // one face handed from classification to emission
   typedef struct packed {
      logic            mesh_select;
      logic            cell_owns;
      logic            overflow;
      logic [1:0]      axis;
      logic [PosW-1:0] pos_x;
      logic [PosW-1:0] pos_y;
      logic [PosW-1:0] pos_z;
      logic [7:0]      layer;
      logic [IdxW-1:0] base_index;
   } face_type;

   typedef struct packed {
      logic            kind;
      logic            mesh_select;
      logic [PosW-1:0] pos_x;
      logic [PosW-1:0] pos_y;
      logic [PosW-1:0] pos_z;
      logic            tex_u;
      logic            tex_v;
      logic [7:0]      layer;
      logic [IdxW-1:0] index_value;
      logic            overflow;
      logic            last;
   } record_type;

endpackage

[rtl/core/vfm_req_if.sv]
interface vfm_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [3:0] cell_x;
   logic [3:0] cell_y;
   logic [3:0] cell_z;
   logic [1:0] axis;
   logic [7:0] cell_id;
   logic [7:0] neighbor_id;
   logic [7:0] cell_layer;
   logic [7:0] neighbor_layer;

   modport source (
      output valid, opcode, cell_x, cell_y, cell_z, axis, cell_id, neighbor_id,
             cell_layer, neighbor_layer,
      input  ready
   );
   modport sink (
      input  valid, opcode, cell_x, cell_y, cell_z, axis, cell_id, neighbor_id,
             cell_layer, neighbor_layer,
      output ready
   );
endinterface

[rtl/core/vfm_rsp_if.sv]
interface vfm_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic        mesh_select;
   logic [4:0]  pos_x;
   logic [4:0]  pos_y;
   logic [4:0]  pos_z;
   logic        tex_u;
   logic        tex_v;
   logic [7:0]  layer;
   logic [15:0] index_value;
   logic        overflow;
   logic        last;

   modport source (
      output valid, kind, mesh_select, pos_x, pos_y, pos_z, tex_u, tex_v, layer,
             index_value, overflow, last,
      input  ready
   );
   modport sink (
      input  valid, kind, mesh_select, pos_x, pos_y, pos_z, tex_u, tex_v, layer,
             index_value, overflow, last,
      output ready
   );
endinterface

[rtl/core/vfm_csr_if.sv]
interface vfm_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] liquid_id;

   modport source (output valid, liquid_id, input ready);
   modport sink (input valid, liquid_id, output ready);
endinterface

[rtl/core/vfm_front.sv]
module vfm_front (
   input  logic              clock,
   input  logic              reset,
   vfm_req_if.sink           req,
   vfm_csr_if.sink           csr,
   input  logic              q_full,
   output logic              q_push,
   output vfm_pkg::face_type q_face
);

   logic [vfm_pkg::IdW-1:0]  liquid_ff;
   logic [vfm_pkg::CntW-1:0] opaque_cnt_ff, opaque_cnt_in;
   logic [vfm_pkg::CntW-1:0] clear_cnt_ff, clear_cnt_in;

   logic                     accept;
   logic                     in_chunk;
   logic                     c_empty, n_empty, c_clear, n_clear;
   logic                     has_face, cell_owns, to_clear;
   logic [vfm_pkg::IdW-1:0]  owner_id;
   logic [vfm_pkg::CntW:0]   cnt_sum;
   logic [vfm_pkg::CntW-1:0] cnt_old, cnt_new, cnt_base;

   assign csr.ready = 1'b1;
   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         liquid_ff <= vfm_pkg::LiquidRst;
      end else if (csr.valid) begin
         liquid_ff <= csr.liquid_id;
      end
   end

   always_comb begin
      in_chunk = (32'(req.cell_x) < vfm_pkg::CHUNK_SIZE) &&
                 (32'(req.cell_y) < vfm_pkg::CHUNK_SIZE) &&
                 (32'(req.cell_z) < vfm_pkg::CHUNK_SIZE);
      c_empty  = req.cell_id == vfm_pkg::IdEmpty;
      n_empty  = req.neighbor_id == vfm_pkg::IdEmpty;
      c_clear  = c_empty || req.cell_id == liquid_ff;
      n_clear  = n_empty || req.neighbor_id == liquid_ff;
      has_face = req.opcode == vfm_pkg::OpTest && req.axis <= vfm_pkg::AxisZ && in_chunk &&
                 (c_empty != n_empty || c_clear != n_clear);
      // emptiness decides first, transparency second
      cell_owns = (c_empty != n_empty) ? !c_empty : !c_clear;
      owner_id  = cell_owns ? req.cell_id : req.neighbor_id;
      to_clear  = owner_id == liquid_ff && owner_id != vfm_pkg::IdEmpty;

      cnt_old  = to_clear ? clear_cnt_ff : opaque_cnt_ff;
      cnt_sum  = {1'b0, cnt_old} + {1'b0, vfm_pkg::CntStep};
      cnt_new  = (cnt_sum > {1'b0, vfm_pkg::CntMax}) ? vfm_pkg::CntMax
                                                       : cnt_sum[vfm_pkg::CntW-1:0];
      cnt_base = cnt_new - vfm_pkg::CntStep;
   end

   always_comb begin
      opaque_cnt_in = opaque_cnt_ff;
      clear_cnt_in  = clear_cnt_ff;
      if (accept && req.opcode == vfm_pkg::OpStart) begin
         opaque_cnt_in = '0;
         clear_cnt_in  = '0;
      end else if (accept && has_face) begin
         if (to_clear) begin
            clear_cnt_in = cnt_new;
         end else begin
            opaque_cnt_in = cnt_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opaque_cnt_ff <= '0;
         clear_cnt_ff  <= '0;
      end else begin
         opaque_cnt_ff <= opaque_cnt_in;
         clear_cnt_ff  <= clear_cnt_in;
      end
   end

   always_comb begin
      q_push                = accept && has_face;
      q_face.mesh_select    = to_clear ? vfm_pkg::MeshClear : vfm_pkg::MeshOpaque;
      q_face.cell_owns      = cell_owns;
      q_face.overflow       = cnt_new > vfm_pkg::CapLimit;
      q_face.axis           = req.axis;
      // neighbor sits one step up the axis; the shared face is on its near side
      q_face.pos_x          = {1'b0, req.cell_x} + {4'b0, req.axis == vfm_pkg::AxisX};
      q_face.pos_y          = {1'b0, req.cell_y} + {4'b0, req.axis == vfm_pkg::AxisY};
      q_face.pos_z          = {1'b0, req.cell_z} + {4'b0, req.axis == vfm_pkg::AxisZ};
      q_face.layer          = cell_owns ? req.cell_layer : req.neighbor_layer;
      q_face.base_index     = cnt_base[vfm_pkg::IdxW-1:0];
   end

endmodule

[rtl/core/vfm_queue.sv]
module vfm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  vfm_pkg::face_type push_face,
   input  logic              pop,
   output vfm_pkg::face_type head,
   output logic              full,
   output logic              empty
);

   vfm_pkg::face_type          entry_ff [vfm_pkg::QueueDepth];
   logic [vfm_pkg::QPtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [vfm_pkg::QPtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [vfm_pkg::QCntW-1:0]  count_ff, count_in;

   assign full  = count_ff == vfm_pkg::QCntW'(vfm_pkg::QueueDepth);
   assign empty = count_ff == '0;
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == vfm_pkg::QPtrW'(vfm_pkg::QueueDepth - 1)) ? '0
                                                                             : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == vfm_pkg::QPtrW'(vfm_pkg::QueueDepth - 1)) ? '0
                                                                             : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_face;
      end
   end

endmodule

[rtl/core/vfm_back.sv]
module vfm_back (
   input  logic              clock,
   input  logic              reset,
   input  vfm_pkg::face_type q_head,
   input  logic              q_empty,
   output logic              q_pop,
   vfm_rsp_if.source         rsp
);

   logic [vfm_pkg::StepW-1:0] step_ff, step_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   vfm_pkg::record_type       rsp_ff, rsp_in;

   logic                      load;
   logic                      is_vertex;
   logic [1:0]                corner;
   logic [2:0]                tri_k, tri_sel;
   logic [2:0]                qc;
   logic [1:0]                uv;

   assign load  = !q_empty && (!rsp_valid_ff || rsp.ready);
   assign q_pop = load && step_ff == vfm_pkg::LastStep;

   always_comb begin
      is_vertex = step_ff < vfm_pkg::NumVertex;
      corner    = step_ff[1:0];
      tri_k     = 3'(step_ff - vfm_pkg::NumVertex);
      // the neighbor's faces wind the other way
      tri_sel   = q_head.cell_owns ? tri_k : 3'd5 - tri_k;
      qc        = vfm_pkg::QUAD_CORNER[q_head.axis][corner];
      uv        = vfm_pkg::CORNER_UV[q_head.axis][corner];

      rsp_in             = '0;
      rsp_in.mesh_select = q_head.mesh_select;
      rsp_in.overflow    = q_head.overflow;
      if (is_vertex) begin
         rsp_in.kind  = vfm_pkg::KindVertex;
         rsp_in.pos_x = q_head.pos_x + {4'b0, qc[0]};
         rsp_in.pos_y = q_head.pos_y + {4'b0, qc[1]};
         rsp_in.pos_z = q_head.pos_z + {4'b0, qc[2]};
         rsp_in.tex_u = uv[1];
         rsp_in.tex_v = uv[0];
         rsp_in.layer = q_head.layer;
      end else begin
         rsp_in.kind        = vfm_pkg::KindIndex;
         rsp_in.index_value = q_head.base_index + {14'b0, vfm_pkg::TRI_ORDER[tri_sel]};
         rsp_in.last        = step_ff == vfm_pkg::LastStep;
      end
   end

   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         step_in      = (step_ff == vfm_pkg::LastStep) ? '0 : step_ff + 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.kind        = rsp_ff.kind;
   assign rsp.mesh_select = rsp_ff.mesh_select;
   assign rsp.pos_x       = rsp_ff.pos_x;
   assign rsp.pos_y       = rsp_ff.pos_y;
   assign rsp.pos_z       = rsp_ff.pos_z;
   assign rsp.tex_u       = rsp_ff.tex_u;
   assign rsp.tex_v       = rsp_ff.tex_v;
   assign rsp.layer       = rsp_ff.layer;
   assign rsp.index_value = rsp_ff.index_value;
   assign rsp.overflow    = rsp_ff.overflow;
   assign rsp.last        = rsp_ff.last;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= vfm_pkg::LastStep)
      else $error("face step counter out of range");

   a_vertex_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind == vfm_pkg::KindVertex |->
         !rsp_ff.last && rsp_ff.index_value == '0)
      else $error("vertex beat carries index fields");

   a_mid_face: assert property (@(posedge clock) disable iff (reset)
      load && step_ff != vfm_pkg::LastStep |=> step_ff != '0)
      else $error("face sequence restarted before its last beat");

endmodule

[rtl/core/voxel_face_mesher.sv]
// Voxel face mesher. Each request beat tests one cell against its neighbor one
// step up x, y or z (or, with the start opcode, clears both vertex counters).
// A pair that needs a face yields ten response beats: four vertex records and
// then six triangle indices, the last flagged with last; other requests yield
// nothing. Requests are classified combinationally and a visible face is queued
// (four faces deep) for the emitter, which sends one record per cycle while the
// receiver is ready; new faces are queued while a face is being sent. Culled
// pairs and starts are taken every cycle while the queue has room. The liquid id
// register may be written only while the block is idle; it resets to 9.
module voxel_face_mesher (
   input  logic      clock,
   input  logic      reset,
   vfm_req_if.sink   req_chan,
   vfm_rsp_if.source rsp_chan,
   vfm_csr_if.sink   csr_chan
);

   logic              q_push, q_pop, q_full, q_empty;
   vfm_pkg::face_type q_face, q_head;

   vfm_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .csr    (csr_chan),
      .q_full (q_full),
      .q_push (q_push),
      .q_face (q_face)
   );

   vfm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_face (q_face),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   vfm_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_head  (q_head),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .rsp     (rsp_chan)
   );

endmodule

[dv/voxel_face_mesher_test.sv]
`timescale 1ns / 100ps

module voxel_face_mesher_test;

   localparam int unsigned LIMIT_CYCLES  = 3_000_000;
   localparam int unsigned SETTLE_CYCLES = 20;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned PHASE_PAIRS   = 56;

   localparam logic       OP_TEST   = vfm_pkg::OpTest;
   localparam logic       OP_START  = vfm_pkg::OpStart;
   localparam logic [1:0] AXIS_X    = vfm_pkg::AxisX;
   localparam logic [1:0] AXIS_Y    = vfm_pkg::AxisY;
   localparam logic [1:0] AXIS_Z    = vfm_pkg::AxisZ;
   localparam logic [1:0] AXIS_NONE = 2'd3;

   // corner offsets per axis: bit 2 = x, bit 1 = y, bit 0 = z
   localparam logic [2:0] FACE_CORNER [3][4] = '{
      '{3'b000, 3'b001, 3'b011, 3'b010},
      '{3'b000, 3'b100, 3'b101, 3'b001},
      '{3'b100, 3'b000, 3'b010, 3'b110}
   };
   // bit 1 = u, bit 0 = v
   localparam logic [1:0] FACE_UV [3][4] = '{
      '{2'b00, 2'b10, 2'b11, 2'b01},
      '{2'b00, 2'b10, 2'b11, 2'b01},
      '{2'b10, 2'b00, 2'b01, 2'b11}
   };
   localparam logic [1:0] TRI_SEQ [6] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3};

   typedef struct packed {
      logic       opcode;
      logic [3:0] cell_x;
      logic [3:0] cell_y;
      logic [3:0] cell_z;
      logic [1:0] axis;
      logic [7:0] cell_id;
      logic [7:0] neighbor_id;
      logic [7:0] cell_layer;
      logic [7:0] neighbor_layer;
   } pair_type;

   logic clock;
   logic reset;

   vfm_req_if req_bus ();
   vfm_rsp_if rsp_bus ();
   vfm_csr_if csr_bus ();

   voxel_face_mesher dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   pair_type             pending_pairs [$];
   vfm_pkg::record_type  mesh_records [$];
   pair_type             next_pair;

   logic [16:0] opaque_verts = '0;
   logic [16:0] clear_verts  = '0;
   logic [7:0]  liquid_sel;

   int unsigned pairs_queued;
   int unsigned pairs_taken = 0;
   int unsigned beats_seen  = 0;
   int unsigned mismatches  = 0;
   int unsigned cycle_count = 0;
   int unsigned send_gap    = 0;
   int unsigned stall_left  = 0;
   logic        req_fire    = 1'b0;
   logic        tx_gaps_on;
   logic        rx_gaps_on;
   logic        hold_go;
   logic        rsp_hold;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatches++;
      $display("mismatch at beat %0d: %s got %0h expected %0h", beats_seen, what, got,
               want);
   endtask

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // appends the ten records of a visible face, or updates the counters
   function automatic void emit_face_records(input pair_type p);
      logic                c_empty, n_empty, c_clear, n_clear, cell_owns, to_clear, ovf;
      logic [7:0]          owner, lay;
      logic [17:0]         sum;
      logic [16:0]         cnt;
      logic [15:0]         base;
      logic [2:0]          ofs;
      logic [1:0]          uv;
      int                  v, k, sel;
      vfm_pkg::record_type r;
      if (p.opcode == OP_START) begin
         opaque_verts = '0;
         clear_verts  = '0;
         return;
      end
      if (p.axis == AXIS_NONE) return;
      c_empty = p.cell_id == vfm_pkg::IdEmpty;
      n_empty = p.neighbor_id == vfm_pkg::IdEmpty;
      c_clear = c_empty || p.cell_id == liquid_sel;
      n_clear = n_empty || p.neighbor_id == liquid_sel;
      if (c_empty == n_empty && c_clear == n_clear) return;
      cell_owns = (c_empty != n_empty) ? !c_empty : !c_clear;
      owner     = cell_owns ? p.cell_id : p.neighbor_id;
      lay       = cell_owns ? p.cell_layer : p.neighbor_layer;
      to_clear  = owner != vfm_pkg::IdEmpty && owner == liquid_sel;
      sum = {1'b0, (to_clear ? clear_verts : opaque_verts)} + 18'd4;
      cnt = (sum > 18'h1FFFF) ? 17'h1FFFF : sum[16:0];
      if (to_clear) clear_verts = cnt;
      else opaque_verts = cnt;
      ovf  = cnt > 17'(vfm_pkg::VERTEX_CAPACITY);
      base = 16'(cnt - 17'd4);
      for (v = 0; v < 4; v++) begin
         ofs = FACE_CORNER[p.axis][v];
         uv  = FACE_UV[p.axis][v];
         r = '0;
         r.kind        = vfm_pkg::KindVertex;
         r.mesh_select = to_clear ? vfm_pkg::MeshClear : vfm_pkg::MeshOpaque;
         r.pos_x = 5'(p.cell_x) + 5'(ofs[2]) + ((p.axis == AXIS_X) ? 5'd1 : 5'd0);
         r.pos_y = 5'(p.cell_y) + 5'(ofs[1]) + ((p.axis == AXIS_Y) ? 5'd1 : 5'd0);
         r.pos_z = 5'(p.cell_z) + 5'(ofs[0]) + ((p.axis == AXIS_Z) ? 5'd1 : 5'd0);
         r.tex_u    = uv[1];
         r.tex_v    = uv[0];
         r.layer    = lay;
         r.overflow = ovf;
         mesh_records.push_back(r);
      end
      // neighbor-owned faces wind the other way
      for (k = 0; k < 6; k++) begin
         sel = cell_owns ? k : 5 - k;
         r = '0;
         r.kind        = vfm_pkg::KindIndex;
         r.mesh_select = to_clear ? vfm_pkg::MeshClear : vfm_pkg::MeshOpaque;
         r.index_value = base + 16'(TRI_SEQ[sel]);
         r.overflow    = ovf;
         r.last        = (k == 5);
         mesh_records.push_back(r);
      end
   endfunction

   function automatic logic [7:0] pick_id();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 30) return vfm_pkg::IdEmpty;
      if (r < 55) return liquid_sel;
      return 8'($urandom_range(255, 1));
   endfunction

   function automatic pair_type random_pair();
      pair_type    p;
      int unsigned r;
      r = $urandom_range(99);
      p.opcode = (r < 4) ? OP_START : OP_TEST;
      p.cell_x = 4'($urandom_range(15));
      p.cell_y = 4'($urandom_range(15));
      p.cell_z = 4'($urandom_range(15));
      p.axis   = (r >= 4 && r < 9) ? AXIS_NONE : 2'($urandom_range(2));
      p.cell_id        = pick_id();
      p.neighbor_id    = pick_id();
      p.cell_layer     = 8'($urandom_range(255));
      p.neighbor_layer = 8'($urandom_range(255));
      return p;
   endfunction

   task automatic queue_pair(input pair_type p);
      pending_pairs.push_back(p);
      pairs_queued++;
   endtask

   task automatic queue_random(input int unsigned n);
      repeat (n) queue_pair(random_pair());
   endtask

   task automatic wait_idle();
      while (pairs_taken != pairs_queued || mesh_records.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_liquid(input logic [7:0] value);
      @(negedge clock);
      csr_bus.valid     <= 1'b1;
      csr_bus.liquid_id <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      liquid_sel = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid          <= 1'b0;
         req_bus.opcode         <= OP_TEST;
         req_bus.cell_x         <= '0;
         req_bus.cell_y         <= '0;
         req_bus.cell_z         <= '0;
         req_bus.axis           <= AXIS_X;
         req_bus.cell_id        <= '0;
         req_bus.neighbor_id    <= '0;
         req_bus.cell_layer     <= '0;
         req_bus.neighbor_layer <= '0;
      end else if (!req_bus.valid || req_fire) begin
         if (send_gap != 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_pairs.size() != 0) begin
            next_pair = pending_pairs.pop_front();
            req_bus.valid          <= 1'b1;
            req_bus.opcode         <= next_pair.opcode;
            req_bus.cell_x         <= next_pair.cell_x;
            req_bus.cell_y         <= next_pair.cell_y;
            req_bus.cell_z         <= next_pair.cell_z;
            req_bus.axis           <= next_pair.axis;
            req_bus.cell_id        <= next_pair.cell_id;
            req_bus.neighbor_id    <= next_pair.neighbor_id;
            req_bus.cell_layer     <= next_pair.cell_layer;
            req_bus.neighbor_layer <= next_pair.neighbor_layer;
            send_gap = tx_gaps_on ? pick_gap() : 0;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response ready
   always @(negedge clock) begin
      if (reset || rsp_hold) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         stall_left = rx_gaps_on ? pick_gap() : 0;
      end
   end

   // long receiver hold-off so the face queue fills and the input stalls
   initial begin
      rsp_hold = 1'b0;
      wait (hold_go);
      @(negedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      rsp_hold <= 1'b0;
   end

   // monitor and prediction at the accepting edge
   always @(posedge clock) begin
      vfm_pkg::record_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (mesh_records.size() == 0) begin
               report_mismatch("beat with no record pending", 0, 0);
            end else begin
               want = mesh_records.pop_front();
               if (rsp_bus.kind !== want.kind)
                  report_mismatch("kind", rsp_bus.kind, want.kind);
               if (rsp_bus.mesh_select !== want.mesh_select)
                  report_mismatch("mesh_select", rsp_bus.mesh_select, want.mesh_select);
               if (rsp_bus.pos_x !== want.pos_x)
                  report_mismatch("pos_x", rsp_bus.pos_x, want.pos_x);
               if (rsp_bus.pos_y !== want.pos_y)
                  report_mismatch("pos_y", rsp_bus.pos_y, want.pos_y);
               if (rsp_bus.pos_z !== want.pos_z)
                  report_mismatch("pos_z", rsp_bus.pos_z, want.pos_z);
               if (rsp_bus.tex_u !== want.tex_u)
                  report_mismatch("tex_u", rsp_bus.tex_u, want.tex_u);
               if (rsp_bus.tex_v !== want.tex_v)
                  report_mismatch("tex_v", rsp_bus.tex_v, want.tex_v);
               if (rsp_bus.layer !== want.layer)
                  report_mismatch("layer", rsp_bus.layer, want.layer);
               if (rsp_bus.index_value !== want.index_value)
                  report_mismatch("index_value", rsp_bus.index_value, want.index_value);
               if (rsp_bus.overflow !== want.overflow)
                  report_mismatch("overflow", rsp_bus.overflow, want.overflow);
               if (rsp_bus.last !== want.last)
                  report_mismatch("last", rsp_bus.last, want.last);
            end
            beats_seen++;
         end
         req_fire <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            emit_face_records(pair_type'{req_bus.opcode, req_bus.cell_x, req_bus.cell_y,
                                         req_bus.cell_z, req_bus.axis, req_bus.cell_id,
                                         req_bus.neighbor_id, req_bus.cell_layer,
                                         req_bus.neighbor_layer});
            pairs_taken++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      csr_bus.valid     = 1'b0;
      csr_bus.liquid_id = '0;
      liquid_sel   = vfm_pkg::LiquidRst;
      pairs_queued = 0;
      tx_gaps_on   = 1'b1;
      rx_gaps_on   = 1'b1;
      hold_go      = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed pairs with the liquid id at its reset value
      queue_pair(pair_type'{OP_TEST, 4'd0, 4'd0, 4'd0, AXIS_X, 8'd1, 8'd0, 8'd0, 8'd255});
      queue_pair(pair_type'{OP_TEST, 4'd15, 4'd15, 4'd15, AXIS_X, 8'd0, 8'd255, 8'd255, 8'd7});
      queue_pair(pair_type'{OP_TEST, 4'd15, 4'd15, 4'd15, AXIS_Y, 8'd9, 8'd0, 8'hAA, 8'h55});
      queue_pair(pair_type'{OP_TEST, 4'd15, 4'd15, 4'd15, AXIS_Z, 8'd0, 8'd9, 8'h12, 8'hFF});
      queue_pair(pair_type'{OP_TEST, 4'd3, 4'd7, 4'd11, AXIS_X, 8'd200, 8'd9, 8'd1, 8'd2});
      queue_pair(pair_type'{OP_TEST, 4'd8, 4'd4, 4'd2, AXIS_Y, 8'd9, 8'd128, 8'd3, 8'd4});
      // no face: solid/solid, empty/empty, liquid/liquid
      queue_pair(pair_type'{OP_TEST, 4'd5, 4'd5, 4'd5, AXIS_Z, 8'd1, 8'd255, 8'd5, 8'd6});
      queue_pair(pair_type'{OP_TEST, 4'd6, 4'd6, 4'd6, AXIS_X, 8'd0, 8'd0, 8'd7, 8'd8});
      queue_pair(pair_type'{OP_TEST, 4'd7, 4'd7, 4'd7, AXIS_Y, 8'd9, 8'd9, 8'd9, 8'd10});
      // unused axis code is dropped
      queue_pair(pair_type'{OP_TEST, 4'd1, 4'd2, 4'd3, AXIS_NONE, 8'd1, 8'd0, 8'd11, 8'd12});
      queue_pair(pair_type'{OP_TEST, 4'd10, 4'd0, 4'd5, AXIS_Z, 8'd0, 8'd77, 8'd13, 8'd14});
      queue_pair(pair_type'{OP_START, 4'd9, 4'd3, 4'd12, AXIS_Y, 8'd4, 8'd0, 8'd15, 8'd16});
      queue_pair(pair_type'{OP_TEST, 4'd0, 4'd15, 4'd0, AXIS_Z, 8'd255, 8'd0, 8'd17, 8'd18});
      queue_pair(pair_type'{OP_TEST, 4'd15, 4'd0, 4'd15, AXIS_Y, 8'd0, 8'd1, 8'd19, 8'd20});
      queue_pair(pair_type'{OP_TEST, 4'd0, 4'd0, 4'd0, AXIS_Y, 8'd9, 8'd0, 8'd21, 8'd22});
      queue_pair(pair_type'{OP_START, 4'd15, 4'd15, 4'd15, AXIS_NONE, 8'd255, 8'd255, 8'd255,
                            8'd255});
      queue_pair(pair_type'{OP_TEST, 4'd2, 4'd13, 4'd8, AXIS_X, 8'd0, 8'd9, 8'd23, 8'd24});
      wait_idle();

      // liquid id 0: every non-empty id is opaque
      write_liquid(8'd0);
      queue_random(PHASE_PAIRS);
      wait_idle();

      // receiver holds off while the sender pushes back to back
      write_liquid(8'd255);
      tx_gaps_on = 1'b0;
      hold_go    = 1'b1;
      queue_random(PHASE_PAIRS);
      wait_idle();
      tx_gaps_on = 1'b1;

      write_liquid(8'($urandom_range(254, 1)));
      queue_random(PHASE_PAIRS);
      wait_idle();

      // no idling on either side
      write_liquid(vfm_pkg::LiquidRst);
      tx_gaps_on = 1'b0;
      rx_gaps_on = 1'b0;
      queue_pair(pair_type'{OP_START, 4'd0, 4'd0, 4'd0, AXIS_X, 8'd0, 8'd0, 8'd0, 8'd0});
      queue_random(PHASE_PAIRS);
      wait_idle();
      tx_gaps_on = 1'b1;
      rx_gaps_on = 1'b1;

      write_liquid(8'($urandom_range(254, 1)));
      queue_pair(pair_type'{OP_START, 4'd0, 4'd0, 4'd0, AXIS_X, 8'd0, 8'd0, 8'd0, 8'd0});
      queue_random(PHASE_PAIRS);
      wait_idle();

      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/vfm_pkg.sv
rtl/core/vfm_req_if.sv
rtl/core/vfm_rsp_if.sv
rtl/core/vfm_csr_if.sv
rtl/core/vfm_front.sv
rtl/core/vfm_queue.sv
rtl/core/vfm_back.sv
rtl/core/voxel_face_mesher.sv
dv/voxel_face_mesher_test.sv
